// ===== src/tspsa_pkg.sv =====
// Shared types and constants for the transport-stream packet aligner.
package tspsa_pkg;

    localparam int PACKET_BYTES   = 188;
    localparam int LENGTH_BITS    = 20;
    localparam int WORD_LANES     = 8;
    localparam int WORDS          = (PACKET_BYTES + WORD_LANES - 1) / WORD_LANES;
    localparam int ROW_BITS       = $clog2(WORDS);
    localparam int LANE_BITS      = $clog2(WORD_LANES);
    localparam int FILL_BITS      = $clog2(PACKET_BYTES + 1);
    localparam int LAST_BYTES     = PACKET_BYTES - WORD_LANES * (WORDS - 1);

    localparam logic [7:0] SYNC_BYTE = 8'h47;
    localparam logic [63:0] LAST_WORD_MASK = (64'd1 << (8 * LAST_BYTES)) - 64'd1;

    // One input word: a stream byte and its buffer tags
    typedef struct packed {
        logic [7:0]             data_byte;
        logic                   first_of_buffer;
        logic [LENGTH_BITS-1:0] buffer_length;
    } in_item_t;

    // One output word of a finished packet
    typedef struct packed {
        logic [63:0] packet_word;
        logic [3:0]  word_bytes;
        logic        last_word;
    } out_item_t;

    // Byte write into the packet store
    typedef struct packed {
        logic                en;
        logic [ROW_BITS-1:0] row;
        logic [LANE_BITS-1:0] lane;
        logic [7:0]          data;
    } store_wr_t;

endpackage

// ===== src/tspsa_store.sv =====
// Packet store: rows of eight bytes, byte-lane write, registered row read.
module tspsa_store (
    input  logic                          clk,
    input  tspsa_pkg::store_wr_t          wr,
    input  logic                          rd_en,
    input  logic [tspsa_pkg::ROW_BITS-1:0] rd_row,
    output logic [63:0]                   rd_data
);

    logic [63:0] mem [tspsa_pkg::WORDS];
    logic [63:0] rd_data_reg;

    // Byte-lane write
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.row][{wr.lane, 3'b000} +: 8] <= wr.data;
        end
    end

    // Registered row read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_row];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/tspsa_scan.sv =====
// Per-byte sync search, capture, tail residue and completion control.
module tspsa_scan (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  tspsa_pkg::in_item_t  item,
    input  logic                 cfg_we,
    input  logic                 cfg_data,
    output tspsa_pkg::store_wr_t wr,
    output logic                 done
);

    localparam logic [1:0] MODE_SEARCH   = 2'd0;
    localparam logic [1:0] MODE_CAPTURE  = 2'd1;
    localparam logic [1:0] MODE_TAIL     = 2'd2;
    localparam logic [1:0] MODE_COMPLETE = 2'd3;

    localparam int LB = tspsa_pkg::LENGTH_BITS;
    localparam int FB = tspsa_pkg::FILL_BITS;
    localparam logic [LB-1:0] POS_MAX = {LB{1'b1}};
    localparam logic [LB:0]   PKT_LEN = (LB+1)'(tspsa_pkg::PACKET_BYTES);
    localparam logic [FB-1:0] FILL_LAST = FB'(tspsa_pkg::PACKET_BYTES - 1);

    logic          enable_reg;
    logic [FB-1:0] fill_reg, fill_next;
    logic [LB-1:0] pos_reg, pos_next;
    logic [1:0]    mode_reg, mode_next;
    logic          ignored_reg, ignored_next;

    logic [LB-1:0] pos_base;
    logic [1:0]    mode_base;
    logic          room_ok;
    logic          wr_en;
    logic [FB-1:0] wr_addr;
    logic          do_gather;
    logic          do_scan;

    // Next state for one accepted byte
    always_comb
    begin
        pos_next     = pos_reg;
        mode_next    = mode_reg;
        fill_next    = fill_reg;
        ignored_next = ignored_reg;
        wr_en        = 1'b0;
        wr_addr      = fill_reg;
        done         = 1'b0;
        do_gather    = 1'b0;
        do_scan      = 1'b0;

        if (item.first_of_buffer)
        begin
            pos_base     = '0;
            mode_base    = MODE_SEARCH;
            ignored_next = !(enable_reg && ({1'b0, item.buffer_length} >= PKT_LEN));
        end
        else
        begin
            pos_base  = pos_reg;
            mode_base = mode_reg;
        end

        // At least a whole packet left in the buffer from here on
        room_ok = {1'b0, item.buffer_length} >= ({1'b0, pos_base} + PKT_LEN);

        if (accept)
        begin
            pos_next  = (pos_base < POS_MAX) ? pos_base + LB'(1) : pos_base;
            mode_next = mode_base;

            if (!ignored_next)
            begin
                if (item.first_of_buffer)
                begin
                    if (fill_reg != '0 && item.data_byte != tspsa_pkg::SYNC_BYTE)
                    begin
                        mode_next = MODE_COMPLETE;
                        do_gather = 1'b1;
                    end
                    else
                    begin
                        fill_next = '0;
                        do_scan   = 1'b1;
                    end
                end
                else
                begin
                    case (mode_base)
                        MODE_CAPTURE,
                        MODE_COMPLETE: do_gather = 1'b1;
                        MODE_TAIL:
                        begin
                            if (fill_reg < FILL_LAST)
                            begin
                                wr_en     = 1'b1;
                                fill_next = fill_reg + FB'(1);
                            end
                        end
                        default: do_scan = 1'b1;
                    endcase
                end

                // Add to the packet; the final byte hands the packet over
                if (do_gather)
                begin
                    wr_en = 1'b1;
                    if (fill_reg == FILL_LAST)
                    begin
                        fill_next = '0;
                        mode_next = MODE_SEARCH;
                        done      = 1'b1;
                    end
                    else
                    begin
                        fill_next = fill_reg + FB'(1);
                    end
                end

                // Sync byte opens a packet or a residue
                if (do_scan && item.data_byte == tspsa_pkg::SYNC_BYTE)
                begin
                    wr_en     = 1'b1;
                    wr_addr   = '0;
                    fill_next = FB'(1);
                    mode_next = room_ok ? MODE_CAPTURE : MODE_TAIL;
                end
            end
        end
        else
        begin
            ignored_next = ignored_reg;
        end
    end

    assign wr.en   = wr_en;
    assign wr.row  = wr_addr[tspsa_pkg::LANE_BITS +: tspsa_pkg::ROW_BITS];
    assign wr.lane = wr_addr[tspsa_pkg::LANE_BITS-1:0];
    assign wr.data = item.data_byte;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            fill_reg    <= '0;
            pos_reg     <= '0;
            mode_reg    <= MODE_SEARCH;
            ignored_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                enable_reg <= cfg_data;
            end
            fill_reg    <= fill_next;
            pos_reg     <= pos_next;
            mode_reg    <= mode_next;
            ignored_reg <= ignored_next;
        end
    end

endmodule

// ===== src/tspsa_emit.sv =====
// Read-out sequencer: walks the store rows and drives the output word.
module tspsa_emit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [63:0]                    rd_data,
    output logic                           rd_en,
    output logic [tspsa_pkg::ROW_BITS-1:0] rd_row,
    input  logic                           out_ready,
    output logic                           out_valid,
    output tspsa_pkg::out_item_t           out_word,
    output logic                           busy
);

    localparam int RB = tspsa_pkg::ROW_BITS;
    localparam int CB = $clog2(tspsa_pkg::WORDS + 1);
    localparam logic [CB-1:0] ROW_END = CB'(tspsa_pkg::WORDS);
    localparam logic [RB-1:0] ROW_LAST = RB'(tspsa_pkg::WORDS - 1);

    logic                  busy_reg;
    logic [CB-1:0]         next_row_reg;
    logic                  inflight_reg;
    logic [RB-1:0]         ret_row_reg;
    logic                  out_valid_reg;
    tspsa_pkg::out_item_t  out_reg;
    logic                  slot_free;
    logic                  ret_last;

    // Issue a read only when the output slot is free on return
    assign slot_free = !out_valid_reg || out_ready;
    assign rd_en     = busy_reg && (next_row_reg != ROW_END) && !inflight_reg && slot_free;
    assign rd_row    = next_row_reg[RB-1:0];
    assign ret_last  = (ret_row_reg == ROW_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            next_row_reg  <= '0;
            inflight_reg  <= 1'b0;
            ret_row_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                busy_reg     <= 1'b1;
                next_row_reg <= '0;
            end
            else if (rd_en)
            begin
                next_row_reg <= next_row_reg + CB'(1);
            end

            inflight_reg <= rd_en;
            if (rd_en)
            begin
                ret_row_reg <= rd_row;
            end

            // Output slot: filled on read return, emptied on accept
            if (inflight_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (out_valid_reg && out_ready && out_reg.last_word)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Output payload, final word keeps only its valid lanes
    always_ff @(posedge clk)
    begin
        if (inflight_reg)
        begin
            out_reg.packet_word <= ret_last ? (rd_data & tspsa_pkg::LAST_WORD_MASK) : rd_data;
            out_reg.word_bytes  <= ret_last ? 4'(tspsa_pkg::LAST_BYTES)
                                            : 4'(tspsa_pkg::WORD_LANES);
            out_reg.last_word   <= ret_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;
    assign busy      = busy_reg;

endmodule

// ===== src/ts_packet_sync_aligner_unit.sv =====
// Top level of the transport-stream packet aligner.
//
// Input channel (in_valid/in_ready/in_word): one stream byte per word with
// its first-of-buffer mark and buffer length. One per cycle unless in read-out.
// Output channel (out_valid/out_ready/out_word): each 188-byte packet leaves
// as 24 words of eight bytes, the last word carrying four, first byte low.
// Configuration channel (cfg_valid/cfg_ready/cfg_data): the enable bit,
// always ready; it acts from the next first-of-buffer byte.
// Throughput: one byte per cycle while a packet is being gathered. The byte
// that completes a packet stalls the input until all 24 words have gone:
// the store has one row read port and a row is read only when no read is in
// flight and the output slot is free, so the input is held off for the whole
// read-out, plus any out_ready stall. Each word passes the store read register
// and then the output slot; the next row is read once the last has returned.
// Reset clears all control state; the packet store is not cleared and needs
// no clearing pass. A stalled receiver holds the current word and the
// read-out simply waits.
module ts_packet_sync_aligner_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tspsa_pkg::in_item_t  in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tspsa_pkg::out_item_t out_word,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data
);

    tspsa_pkg::store_wr_t          wr;
    logic                          done;
    logic                          busy;
    logic                          rd_en;
    logic [tspsa_pkg::ROW_BITS-1:0] rd_row;
    logic [63:0]                   rd_data;

    // Input held off during packet read-out
    assign in_ready  = !busy;
    assign cfg_ready = 1'b1;

    tspsa_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (in_valid && in_ready),
        .item     (in_word),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .wr       (wr),
        .done     (done)
    );

    tspsa_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_row  (rd_row),
        .rd_data (rd_data)
    );

    tspsa_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (done),
        .rd_data   (rd_data),
        .rd_en     (rd_en),
        .rd_row    (rd_row),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_word  (out_word),
        .busy      (busy)
    );

endmodule

// ===== tb/tb_ts_packet_sync_aligner_unit.sv =====
// Self-checking testbench for the transport-stream packet aligner: directed buffers, then random ones.
module tb_ts_packet_sync_aligner_unit;

    import tspsa_pkg::*;

    // Scan states of the aligner shadow
    typedef enum logic [1:0] {
        SEEK_SYNC,
        TAKE_PACKET,
        HOLD_RESIDUE,
        FINISH_RESIDUE
    } scan_mode_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    in_item_t   in_word   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_item_t  out_word;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data  = 1'b0;

    // Stimulus and expected words
    in_item_t   stream_bytes [$];
    out_item_t  expected_words [$];
    int unsigned mismatch_count  = 0;
    int unsigned carry_bytes     = 0;

    // Aligner shadow state
    logic [7:0]             packet_bytes [PACKET_BYTES];
    int unsigned            fill_level    = 0;
    logic [LENGTH_BITS-1:0] byte_pos      = '0;
    scan_mode_t             scan_state    = SEEK_SYNC;
    bit                     skip_buffer   = 1'b0;
    bit                     enable_shadow = 1'b0;

    // Sender and receiver pacing
    int burst_left   = 1;
    int gap_left     = 0;
    int hold_left    = 0;
    int phase_left   = 200;
    bit stall_phase  = 1'b0;

    ts_packet_sync_aligner_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic note_failure(string msg);
        mismatch_count++;
        $display("%s", msg);
    endtask

    // Splits a finished packet into 24 output words
    function automatic void emit_packet_words();
        out_item_t w;
        int idx;
        for (int r = 0; r < WORDS; r++)
        begin
            w = '0;
            for (int k = 0; k < WORD_LANES; k++)
            begin
                idx = r * WORD_LANES + k;
                if (idx < PACKET_BYTES)
                begin
                    w.packet_word[8*k +: 8] = packet_bytes[idx];
                    w.word_bytes = w.word_bytes + 4'd1;
                end
            end
            w.last_word = (r == WORDS - 1);
            expected_words.push_back(w);
        end
    endfunction

    function automatic void gather_packet_byte(logic [7:0] b);
        if (fill_level < PACKET_BYTES)
            packet_bytes[fill_level] = b;
        fill_level++;
        if (fill_level >= PACKET_BYTES)
        begin
            fill_level = 0;
            scan_state = SEEK_SYNC;
            emit_packet_words();
        end
    endfunction

    // A sync byte opens a packet, or residue when too few bytes remain
    function automatic void seek_sync(logic [7:0] b, int unsigned left);
        if (b == SYNC_BYTE)
        begin
            fill_level      = 1;
            packet_bytes[0] = b;
            scan_state      = (left >= PACKET_BYTES) ? TAKE_PACKET : HOLD_RESIDUE;
        end
    endfunction

    // Advances the shadow by one accepted stream byte
    function automatic void advance_aligner(in_item_t w);
        int unsigned here;
        int unsigned left;
        int unsigned blen;
        blen = 32'(w.buffer_length);
        if (w.first_of_buffer)
        begin
            byte_pos    = '0;
            scan_state  = SEEK_SYNC;
            skip_buffer = !(enable_shadow && blen >= PACKET_BYTES);
        end
        here = 32'(byte_pos);
        if (byte_pos != '1)
            byte_pos++;
        if (skip_buffer)
            return;
        left = (blen > here) ? blen - here : 0;
        if (w.first_of_buffer)
        begin
            // residue is completed unless the new buffer opens on a sync byte
            if (fill_level > 0 && w.data_byte != SYNC_BYTE)
            begin
                scan_state = FINISH_RESIDUE;
                gather_packet_byte(w.data_byte);
            end
            else
            begin
                fill_level = 0;
                seek_sync(w.data_byte, left);
            end
            return;
        end
        case (scan_state)
            TAKE_PACKET, FINISH_RESIDUE: gather_packet_byte(w.data_byte);
            HOLD_RESIDUE:
                if (fill_level < PACKET_BYTES - 1)
                begin
                    packet_bytes[fill_level] = w.data_byte;
                    fill_level++;
                end
            default: seek_sync(w.data_byte, left);
        endcase
    endfunction

    task automatic queue_byte(logic [7:0] b, logic first, int unsigned len);
        in_item_t w;
        w.data_byte       = b;
        w.first_of_buffer = first;
        w.buffer_length   = LENGTH_BITS'(len);
        stream_bytes.push_back(w);
    endtask

    // Non-first bytes of random value; sync bytes optionally avoided
    task automatic queue_body(int n, int unsigned len, bit sync_ok);
        logic [7:0] b;
        repeat (n)
        begin
            b = 8'($urandom);
            if (!sync_ok && b == SYNC_BYTE)
                b = ~b;
            queue_byte(b, 1'b0, len);
        end
    endtask

    // One buffer of mostly aligned packets, carrying on any open residue
    task automatic queue_buffer(int unsigned len, int unsigned count, bit noisy);
        int unsigned run;
        int unsigned tag;
        logic [7:0]  b;
        run = (carry_bytes > 0 && $urandom_range(0, 3) != 0) ? carry_bytes : 0;
        for (int unsigned p = 0; p < count; p++)
        begin
            tag = len;
            if (noisy)
            begin
                b = ($urandom_range(0, 5) == 0) ? SYNC_BYTE : 8'($urandom);
                if ($urandom_range(0, 15) == 0)
                    tag = $urandom_range(0, (1 << LENGTH_BITS) - 1);
            end
            else if (run > 0)
            begin
                b = 8'($urandom);
                if (p == 0 && b == SYNC_BYTE)
                    b = ~b;
                run--;
            end
            else if ($urandom_range(0, 5) != 0)
            begin
                b   = SYNC_BYTE;
                run = PACKET_BYTES - 1;
            end
            else
            begin
                b = 8'($urandom);
                if (b == SYNC_BYTE)
                    b = ~b;
            end
            queue_byte(b, p == 0, tag);
        end
        carry_bytes = run;
    endtask

    // Waits until every byte is in and every word out, then lets the block settle
    task automatic settle();
        @(negedge clk);
        while (stream_bytes.size() != 0 || in_valid || expected_words.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_enable(bit v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        enable_shadow = v;
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Sender: bursts of words with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_word  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                advance_aligner(in_word);
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (stream_bytes.size() != 0)
                begin
                    in_word  <= stream_bytes.pop_front();
                    in_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 60);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each word, stalls in phases
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                    note_failure($sformatf("%0t: expected no word, actual %h", $time, out_word));
                else
                begin
                    automatic out_item_t want = expected_words.pop_front();
                    if (out_word.packet_word !== want.packet_word)
                        note_failure($sformatf("%0t: packet_word expected %h, actual %h",
                                               $time, want.packet_word, out_word.packet_word));
                    if (out_word.word_bytes !== want.word_bytes)
                        note_failure($sformatf("%0t: word_bytes expected %0d, actual %0d",
                                               $time, want.word_bytes, out_word.word_bytes));
                    if (out_word.last_word !== want.last_word)
                        note_failure($sformatf("%0t: last_word expected %b, actual %b",
                                               $time, want.last_word, out_word.last_word));
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (stall_phase && $urandom_range(0, 4) == 0)
                    hold_left = $urandom_range(1, 12);
            end
            phase_left--;
            if (phase_left <= 0)
            begin
                stall_phase = !stall_phase;
                phase_left  = $urandom_range(100, 600);
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        int unsigned random_bytes;
        int unsigned len;
        int unsigned count;
        bit          noisy;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Before any first mark: bytes count as an accepted buffer, even while disabled
        queue_byte(8'h12, 1'b0, 10);
        queue_byte(SYNC_BYTE, 1'b0, 10);
        queue_body(4, 10, 1'b1);
        // disabled: buffer of the largest length is ignored, residue kept
        queue_byte(SYNC_BYTE, 1'b1, (1 << LENGTH_BITS) - 1);
        queue_body(2, (1 << LENGTH_BITS) - 1, 1'b1);
        settle();
        write_enable(1'b1);

        // zero and just-too-short lengths are ignored
        queue_byte(SYNC_BYTE, 1'b1, 0);
        queue_byte(SYNC_BYTE, 1'b0, 0);
        queue_byte(SYNC_BYTE, 1'b1, PACKET_BYTES - 1);
        queue_body(1, PACKET_BYTES - 1, 1'b1);
        // non-sync start completes residue; tail sync and bytes beyond the length leave residue
        queue_byte(8'hFF, 1'b1, PACKET_BYTES);
        queue_body(182, PACKET_BYTES, 1'b1);
        queue_byte(SYNC_BYTE, 1'b0, PACKET_BYTES);
        queue_body(6, PACKET_BYTES, 1'b1);
        // sync at buffer start drops residue; tail leaves fresh residue
        queue_byte(SYNC_BYTE, 1'b1, 200);
        queue_body(187, 200, 1'b1);
        queue_body(3, 200, 1'b0);
        queue_byte(SYNC_BYTE, 1'b0, 200);
        queue_body(4, 200, 1'b1);
        // capture cut short; enable changes mid-buffer only act at the next first mark
        queue_byte(SYNC_BYTE, 1'b1, (1 << LENGTH_BITS) - 1);
        queue_body(9, (1 << LENGTH_BITS) - 1, 1'b1);
        settle();
        write_enable(1'b0);
        queue_body(5, (1 << LENGTH_BITS) - 1, 1'b1);
        queue_byte(SYNC_BYTE, 1'b1, 400);
        queue_body(1, 400, 1'b1);
        settle();
        write_enable(1'b1);
        queue_body(2, 400, 1'b1);
        // sync at the next accepted buffer drops the kept residue
        queue_byte(SYNC_BYTE, 1'b1, 200);
        queue_body(3, 200, 1'b1);
        settle();

        // Short random buffers under random enable settings
        carry_bytes  = 0;
        random_bytes = 0;
        do
        begin
            write_enable($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 2))
            begin
                noisy = 1'b0;
                case ($urandom_range(0, 15))
                    0:
                    begin
                        len   = $urandom_range(0, PACKET_BYTES - 1);
                        count = $urandom_range(1, 40);
                    end
                    1:
                    begin
                        len   = $urandom_range(PACKET_BYTES, (1 << LENGTH_BITS) - 1);
                        count = $urandom_range(1, 300);
                    end
                    2:
                    begin
                        len   = $urandom_range(PACKET_BYTES, 400);
                        count = len + $urandom_range(1, 200);
                    end
                    3:
                    begin
                        len   = $urandom_range(PACKET_BYTES, 400);
                        count = len;
                        noisy = 1'b1;
                    end
                    default:
                    begin
                        len   = $urandom_range(PACKET_BYTES, 420);
                        count = ($urandom_range(0, 4) == 0) ? len - $urandom_range(1, 60) : len;
                    end
                endcase
                // keep the whole run near its byte budget
                if (count > 40)
                    count = $urandom_range(10, 40);
                queue_buffer(len, count, noisy);
                random_bytes += count;
            end
            settle();
        end
        while (random_bytes < 60);

        // Final drain, bounded
        for (int i = 0; i < 20000; i++)
        begin
            if (stream_bytes.size() == 0 && !in_valid && expected_words.size() == 0)
                break;
            @(negedge clk);
        end
        repeat (20) @(negedge clk);
        if (expected_words.size() != 0)
            note_failure($sformatf("%0t: %0d expected words never arrived",
                                   $time, expected_words.size()));
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
src/tspsa_pkg.sv
src/tspsa_store.sv
src/tspsa_scan.sv
src/tspsa_emit.sv
src/ts_packet_sync_aligner_unit.sv
tb/tb_ts_packet_sync_aligner_unit.sv
